// ===== hw/rtl/tcw_pkg.sv =====
// Shared types and constants for the text console cell writer.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

	// Fixed field widths
	localparam int CMD_W      = 2;
	localparam int CHAR_W     = 8;
	localparam int COL_W      = 7;
	localparam int ROW_W      = 6;
	localparam int WORD_W     = 32;
	localparam int IDX_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Reset values of the cursor and the configuration registers
	localparam logic [COL_W-1:0] CURSOR_X_RST     = 7'd24;
	localparam logic [ROW_W-1:0] CURSOR_Y_RST     = 6'd16;
	localparam logic [COL_W-1:0] START_COLUMN_RST = 7'd5;
	localparam logic [ROW_W-1:0] START_ROW_RST    = 6'd1;
	localparam logic [COL_W-1:0] LINE_WIDTH_RST   = 7'd76;
	localparam logic [ROW_W-1:0] LINE_COUNT_RST   = 6'd32;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CHAR_TILDE = 8'd126;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE   = 2'd0,
		CMD_SET_POS = 2'd1,
		CMD_READ    = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_COLUMN = 2'd0,
		REG_START_ROW    = 2'd1,
		REG_LINE_WIDTH   = 2'd2,
		REG_LINE_COUNT   = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic clear_en;
		logic accept;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
	} ctrl_sts_t;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller state machine: clearing pass, item accept, commit and result handshake.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  tcw_pkg::ctrl_sts_t  sts,
	output tcw_pkg::ctrl_cmd_t  cmd
);
	import tcw_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Outputs: commit only once the result register is free
	always_comb begin
		in_ready     = 1'b0;
		cmd.clear_en = 1'b0;
		cmd.accept   = 1'b0;
		cmd.commit   = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clear_en = 1'b1;
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_EXEC: cmd.commit = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid: set on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_commit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("result not presented after commit");

	a_clear_before_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) ##1 (state_q == ST_IDLE) |-> $past(sts.clear_last))
		else $error("clearing pass left early");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_EXEC) && !in_ready)
		else $error("accepted item not executed");

endmodule

// ===== hw/rtl/tcw_dp.sv =====
// Datapath: configuration registers, cursor, palette, cell store and result register.
// Depends on tcw_pkg and tcw_ram.
`timescale 1ns / 1ps

module tcw_dp #(
	parameter int COLUMNS      = 80,
	parameter int ROWS         = 35,
	parameter int PALETTE_SIZE = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tcw_pkg::ctrl_cmd_t                cmd,
	output tcw_pkg::ctrl_sts_t                sts,
	input  logic                              cfg_wr,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [tcw_pkg::CMD_W-1:0]         command,
	input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
	input  logic [tcw_pkg::COL_W-1:0]         pos_col,
	input  logic [tcw_pkg::ROW_W-1:0]         pos_row,
	input  logic [tcw_pkg::WORD_W-1:0]        fg_word,
	input  logic [tcw_pkg::WORD_W-1:0]        bg_word,
	output logic [tcw_pkg::CHAR_W-1:0]        cell_char,
	output logic [tcw_pkg::IDX_W-1:0]         cell_palette_index,
	output logic [tcw_pkg::WORD_W-1:0]        entry_fg,
	output logic [tcw_pkg::WORD_W-1:0]        entry_bg,
	output logic [tcw_pkg::COL_W-1:0]         cursor_col,
	output logic [tcw_pkg::ROW_W-1:0]         cursor_row,
	output logic                              stored,
	output logic                              out_of_grid
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int SW    = $clog2(PALETTE_SIZE);
	localparam int MW    = CHAR_W + SW;

	// Configuration registers
	logic [COL_W-1:0] start_col_q;
	logic [ROW_W-1:0] start_row_q;
	logic [COL_W-1:0] line_width_q;
	logic [ROW_W-1:0] line_count_q;

	// Cursor and palette state
	logic [COL_W-1:0]  cur_x_q;
	logic [ROW_W-1:0]  cur_y_q;
	logic [WORD_W-1:0] pal_fg_q [PALETTE_SIZE];
	logic [WORD_W-1:0] pal_bg_q [PALETTE_SIZE];
	logic [SW-1:0]     rp_q;
	logic [AW-1:0]     clr_addr_q;

	// Captured item
	cmd_t              cmd_q;
	logic [CHAR_W-1:0] char_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [WORD_W-1:0] fg_q;
	logic [WORD_W-1:0] bg_q;
	logic [PALETTE_SIZE-1:0] match_q;

	// Result register
	logic [CHAR_W-1:0] o_char_q;
	logic [IDX_W-1:0]  o_idx_q;
	logic [WORD_W-1:0] o_fg_q;
	logic [WORD_W-1:0] o_bg_q;
	logic [COL_W-1:0]  o_col_q;
	logic [ROW_W-1:0]  o_row_q;
	logic              o_stored_q;
	logic              o_oog_q;

	// Combinational
	logic [PALETTE_SIZE-1:0] match_d;
	logic                    found;
	logic [SW-1:0]           match_idx;
	logic [SW-1:0]           slot;
	logic [SW-1:0]           rp_next;
	logic [AW-1:0]           rd_addr;
	logic [AW-1:0]           cur_addr;
	logic                    rd_in_grid;
	logic                    pos_in_grid;
	logic                    cur_in_grid;
	logic                    printable;
	logic                    do_store;
	logic                    do_insert;
	logic                    ram_wr_en;
	logic [AW-1:0]           ram_wr_addr;
	logic [MW-1:0]           ram_wr_data;
	logic [MW-1:0]           ram_rd_data;
	logic [SW-1:0]           rd_slot;
	logic [COL_W-1:0]        x_inc;
	logic [ROW_W-1:0]        y_inc;
	logic                    newline;
	logic [COL_W-1:0]        nx;
	logic [ROW_W-1:0]        ny;
	logic [CHAR_W-1:0]       r_char;
	logic [SW-1:0]           r_slot;
	logic [WORD_W-1:0]       r_fg;
	logic [WORD_W-1:0]       r_bg;
	logic                    r_stored;
	logic                    r_oog;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_col_q  <= START_COLUMN_RST;
			start_row_q  <= START_ROW_RST;
			line_width_q <= LINE_WIDTH_RST;
			line_count_q <= LINE_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_START_COLUMN: start_col_q  <= cfg_data;
				REG_START_ROW:    start_row_q  <= cfg_data[ROW_W-1:0];
				REG_LINE_WIDTH:   line_width_q <= cfg_data;
				REG_LINE_COUNT:   line_count_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_en && !sts.clear_last) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign sts.clear_last = (clr_addr_q == AW'(CELLS - 1));

	// Palette compare against the incoming pair
	always_comb begin
		for (int i = 0; i < PALETTE_SIZE; i++) begin
			match_d[i] = (pal_fg_q[i] == fg_word) && (pal_bg_q[i] == bg_word);
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q   <= cmd_t'(command);
			char_q  <= char_code;
			col_q   <= pos_col;
			row_q   <= pos_row;
			fg_q    <= fg_word;
			bg_q    <= bg_word;
			match_q <= match_d;
		end
	end

	// Cell addressing
	assign rd_in_grid  = (int'(pos_col) < COLUMNS) && (int'(pos_row) < ROWS);
	assign pos_in_grid = (int'(col_q) < COLUMNS) && (int'(row_q) < ROWS);
	assign cur_in_grid = (int'(cur_x_q) < COLUMNS) && (int'(cur_y_q) < ROWS);
	assign rd_addr     = AW'(pos_row) * AW'(COLUMNS) + AW'(pos_col);
	assign cur_addr    = AW'(cur_y_q) * AW'(COLUMNS) + AW'(cur_x_q);

	// Lowest matching slot wins
	always_comb begin
		found     = 1'b0;
		match_idx = '0;
		for (int i = PALETTE_SIZE - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				found     = 1'b1;
				match_idx = SW'(i);
			end
		end
	end

	assign slot      = found ? match_idx : rp_q;
	assign rp_next   = (rp_q == SW'(PALETTE_SIZE - 1)) ? '0 : rp_q + 1'b1;
	assign printable = (char_q == CHAR_NUL) ||
	                   ((char_q >= CHAR_SPACE) && (char_q <= CHAR_TILDE));
	assign do_store  = cmd.commit && (cmd_q == CMD_WRITE) && cur_in_grid && printable;
	assign do_insert = do_store && !found;

	// Cell store port: clearing pass or commit
	always_comb begin
		if (cmd.clear_en) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = clr_addr_q;
			ram_wr_data = '0;
		end else begin
			ram_wr_en   = do_store;
			ram_wr_addr = cur_addr;
			ram_wr_data = {char_q, slot};
		end
	end

	tcw_ram #(
		.WIDTH(MW),
		.DEPTH(CELLS)
	) u_cells (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (cmd.accept && rd_in_grid),
		.rd_addr(rd_addr),
		.rd_data(ram_rd_data)
	);

	assign rd_slot = ram_rd_data[SW-1:0];

	// Palette insert at the replace pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PALETTE_SIZE; i++) begin
				pal_fg_q[i] <= '0;
				pal_bg_q[i] <= '0;
			end
			rp_q <= '0;
		end else if (do_insert) begin
			pal_fg_q[rp_q] <= fg_q;
			pal_bg_q[rp_q] <= bg_q;
			rp_q           <= rp_next;
		end
	end

	// Cursor advance and result fields
	always_comb begin
		x_inc    = cur_x_q + 1'b1;
		y_inc    = cur_y_q + 1'b1;
		newline  = (char_q == CHAR_CR) || (char_q == CHAR_LF) || (x_inc >= line_width_q);
		nx       = cur_x_q;
		ny       = cur_y_q;
		r_char   = '0;
		r_slot   = '0;
		r_fg     = '0;
		r_bg     = '0;
		r_stored = 1'b0;
		r_oog    = 1'b0;
		unique case (cmd_q)
			CMD_WRITE: begin
				if (newline) begin
					nx = start_col_q;
					ny = (y_inc >= line_count_q) ? start_row_q : y_inc;
				end else begin
					nx = x_inc;
				end
				if (!cur_in_grid) begin
					r_oog = 1'b1;
				end else if (printable) begin
					r_char   = char_q;
					r_slot   = slot;
					r_fg     = fg_q;
					r_bg     = bg_q;
					r_stored = 1'b1;
				end
			end
			CMD_SET_POS: begin
				nx    = start_col_q + col_q;
				ny    = start_row_q + row_q;
				r_oog = !((int'(nx) < COLUMNS) && (int'(ny) < ROWS));
			end
			CMD_READ: begin
				if (pos_in_grid) begin
					r_char = ram_rd_data[MW-1:SW];
					r_slot = rd_slot;
					r_fg   = pal_fg_q[rd_slot];
					r_bg   = pal_bg_q[rd_slot];
				end else begin
					r_oog = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Cursor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= CURSOR_X_RST;
			cur_y_q <= CURSOR_Y_RST;
		end else if (cmd.commit) begin
			cur_x_q <= nx;
			cur_y_q <= ny;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			o_char_q   <= r_char;
			o_idx_q    <= IDX_W'(r_slot);
			o_fg_q     <= r_fg;
			o_bg_q     <= r_bg;
			o_col_q    <= nx;
			o_row_q    <= ny;
			o_stored_q <= r_stored;
			o_oog_q    <= r_oog;
		end
	end

	assign cell_char          = o_char_q;
	assign cell_palette_index = o_idx_q;
	assign entry_fg           = o_fg_q;
	assign entry_bg           = o_bg_q;
	assign cursor_col         = o_col_q;
	assign cursor_row         = o_row_q;
	assign stored             = o_stored_q;
	assign out_of_grid        = o_oog_q;

	a_rp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(rp_q) < PALETTE_SIZE)
		else $error("replace pointer beyond palette");

	a_insert_lands: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> (pal_fg_q[$past(rp_q)] == $past(fg_q)) &&
		              (pal_bg_q[$past(rp_q)] == $past(bg_q)))
		else $error("palette insert lost");

	a_store_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		do_store |=> o_stored_q && !o_oog_q)
		else $error("stored cell flagged outside grid");

endmodule

// ===== hw/rtl/text_console_cell_writer_core.sv =====
// Top level of the text console cell writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl, tcw_dp and tcw_ram.
`timescale 1ns / 1ps

// Character-cell text console. Each item (write character, set cursor, read cell)
// is first captured and then committed: the capture issues the cell-store read and
// compares the colour pair against every palette slot; the commit writes the cell and
// palette, moves the cursor and loads the result register. The next item is
// accepted in the cycle after the commit, so no new item is taken before the last
// one has committed; commit waits as long as the previous result is held. After
// reset a clearing pass zeroes the cell store one cell per cycle, during which no
// item is accepted. Configuration writes
// are taken at any time and act at once, including on an item waiting to commit,
// so issue them only while no item is in flight.

module text_console_cell_writer_core #(
	parameter int COLUMNS      = 80,
	parameter int ROWS         = 35,
	parameter int PALETTE_SIZE = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tcw_pkg::CMD_W-1:0]      command,
	input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
	input  logic [tcw_pkg::COL_W-1:0]      pos_col,
	input  logic [tcw_pkg::ROW_W-1:0]      pos_row,
	input  logic [tcw_pkg::WORD_W-1:0]     fg_word,
	input  logic [tcw_pkg::WORD_W-1:0]     bg_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tcw_pkg::CHAR_W-1:0]     cell_char,
	output logic [tcw_pkg::IDX_W-1:0]      cell_palette_index,
	output logic [tcw_pkg::WORD_W-1:0]     entry_fg,
	output logic [tcw_pkg::WORD_W-1:0]     entry_bg,
	output logic [tcw_pkg::COL_W-1:0]      cursor_col,
	output logic [tcw_pkg::ROW_W-1:0]      cursor_row,
	output logic                           stored,
	output logic                           out_of_grid
);
	import tcw_pkg::*;

	ctrl_cmd_t ctrl_cmd;
	ctrl_sts_t ctrl_sts;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (ctrl_sts),
		.cmd      (ctrl_cmd)
	);

	tcw_dp #(
		.COLUMNS     (COLUMNS),
		.ROWS        (ROWS),
		.PALETTE_SIZE(PALETTE_SIZE)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (ctrl_cmd),
		.sts               (ctrl_sts),
		.cfg_wr            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.command           (command),
		.char_code         (char_code),
		.pos_col           (pos_col),
		.pos_row           (pos_row),
		.fg_word           (fg_word),
		.bg_word           (bg_word),
		.cell_char         (cell_char),
		.cell_palette_index(cell_palette_index),
		.entry_fg          (entry_fg),
		.entry_bg          (entry_bg),
		.cursor_col        (cursor_col),
		.cursor_row        (cursor_row),
		.stored            (stored),
		.out_of_grid       (out_of_grid)
	);

endmodule

// ===== bench/text_console_cell_writer_checker.sv =====
// Scoreboard for the text console cell writer: watches the config, command and
// result channels, keeps its own copy of the console and compares every result.
// Depends on tcw_pkg for the command and register codes.
`timescale 1ns / 1ps

module text_console_cell_writer_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS      = 80,
	parameter int ROWS         = 35,
	parameter int PALETTE_SIZE = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [CMD_W-1:0]      command,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic [COL_W-1:0]      pos_col,
	input  logic [ROW_W-1:0]      pos_row,
	input  logic [WORD_W-1:0]     fg_word,
	input  logic [WORD_W-1:0]     bg_word,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [CHAR_W-1:0]     cell_char,
	input  logic [IDX_W-1:0]      cell_palette_index,
	input  logic [WORD_W-1:0]     entry_fg,
	input  logic [WORD_W-1:0]     entry_bg,
	input  logic [COL_W-1:0]      cursor_col,
	input  logic [ROW_W-1:0]      cursor_row,
	input  logic                  stored,
	input  logic                  out_of_grid,
	output int                    mismatch_count,
	output int                    outstanding
);

	typedef struct packed {
		logic [CHAR_W-1:0] cell_char;
		logic [IDX_W-1:0]  cell_palette_index;
		logic [WORD_W-1:0] entry_fg;
		logic [WORD_W-1:0] entry_bg;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic              stored;
		logic              out_of_grid;
	} console_result_t;

	// Shadow copy of the console
	logic [COL_W-1:0]  start_column, line_width, cur_x;
	logic [ROW_W-1:0]  start_row, line_count, cur_y;
	logic [CHAR_W-1:0] cell_chars [COLUMNS*ROWS];
	logic [IDX_W-1:0]  cell_colours [COLUMNS*ROWS];
	logic [WORD_W-1:0] pal_fg [PALETTE_SIZE];
	logic [WORD_W-1:0] pal_bg [PALETTE_SIZE];
	int                replace_ptr;
	int                fail_total;

	console_result_t expected_cells[$];

	function automatic bit on_grid(int col, int row);
		return col < COLUMNS && row < ROWS;
	endfunction

	// Apply one command to the shadow console and return the result it produces
	function automatic console_result_t console_update(logic [CMD_W-1:0] cmd,
			logic [CHAR_W-1:0] ch, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
			logic [WORD_W-1:0] fg, logic [WORD_W-1:0] bg);
		console_result_t r;
		int              cell_addr;
		int              slot;
		bit              printable;
		r = '0;
		case (cmd)
			CMD_WRITE: begin
				printable = (ch == CHAR_NUL) || (ch >= CHAR_SPACE && ch <= CHAR_TILDE);
				if (!on_grid(int'(cur_x), int'(cur_y))) begin
					r.out_of_grid = 1'b1;
				end else if (printable) begin
					cell_addr = int'(cur_y) * COLUMNS + int'(cur_x);
					// lowest matching slot wins, otherwise insert at the round-robin pointer
					slot = -1;
					for (int i = PALETTE_SIZE - 1; i >= 0; i--)
						if (pal_fg[i] == fg && pal_bg[i] == bg)
							slot = i;
					if (slot < 0) begin
						slot = replace_ptr % PALETTE_SIZE;
						pal_fg[slot] = fg;
						pal_bg[slot] = bg;
						replace_ptr = (slot + 1) % PALETTE_SIZE;
					end
					cell_chars[cell_addr] = ch;
					cell_colours[cell_addr] = IDX_W'(slot);
					r.cell_char = ch;
					r.cell_palette_index = IDX_W'(slot);
					r.entry_fg = pal_fg[slot];
					r.entry_bg = pal_bg[slot];
					r.stored = 1'b1;
				end
				// advance the cursor; CR, LF or the line width start a new line
				cur_x = cur_x + 1'b1;
				if (ch == CHAR_CR || ch == CHAR_LF || cur_x >= line_width) begin
					cur_x = start_column;
					cur_y = cur_y + 1'b1;
					if (cur_y >= line_count)
						cur_y = start_row;
				end
			end
			CMD_SET_POS: begin
				cur_x = start_column + col;
				cur_y = start_row + row;
				r.out_of_grid = !on_grid(int'(cur_x), int'(cur_y));
			end
			CMD_READ: begin
				if (on_grid(int'(col), int'(row))) begin
					cell_addr = int'(row) * COLUMNS + int'(col);
					slot = int'(cell_colours[cell_addr]) % PALETTE_SIZE;
					r.cell_char = cell_chars[cell_addr];
					r.cell_palette_index = IDX_W'(slot);
					r.entry_fg = pal_fg[slot];
					r.entry_bg = pal_bg[slot];
				end else begin
					r.out_of_grid = 1'b1;
				end
			end
			default: ;
		endcase
		r.cursor_col = cur_x;
		r.cursor_row = cur_y;
		return r;
	endfunction

	function automatic void check_field(string name, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
		if (want !== got) begin
			fail_total++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Track config writes, pop and compare results, push predictions
	always @(posedge clk or negedge arst_n) begin : watch
		console_result_t want;
		if (!arst_n) begin
			start_column = START_COLUMN_RST;
			start_row    = START_ROW_RST;
			line_width   = LINE_WIDTH_RST;
			line_count   = LINE_COUNT_RST;
			cur_x        = CURSOR_X_RST;
			cur_y        = CURSOR_Y_RST;
			replace_ptr  = 0;
			fail_total   = 0;
			for (int i = 0; i < COLUMNS * ROWS; i++) begin
				cell_chars[i]   = '0;
				cell_colours[i] = '0;
			end
			for (int i = 0; i < PALETTE_SIZE; i++) begin
				pal_fg[i] = '0;
				pal_bg[i] = '0;
			end
			expected_cells.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					REG_START_COLUMN: start_column = cfg_data[COL_W-1:0];
					REG_START_ROW:    start_row    = cfg_data[ROW_W-1:0];
					REG_LINE_WIDTH:   line_width   = cfg_data[COL_W-1:0];
					REG_LINE_COUNT:   line_count   = cfg_data[ROW_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_cells.size() == 0) begin
					fail_total++;
					$display("%0t: result with no item waiting, actual char %0h cursor %0d,%0d",
						$time, cell_char, cursor_col, cursor_row);
				end else begin
					want = expected_cells.pop_front();
					check_field("cell_char", WORD_W'(want.cell_char), WORD_W'(cell_char));
					check_field("cell_palette_index", WORD_W'(want.cell_palette_index),
						WORD_W'(cell_palette_index));
					check_field("entry_fg", want.entry_fg, entry_fg);
					check_field("entry_bg", want.entry_bg, entry_bg);
					check_field("cursor_col", WORD_W'(want.cursor_col), WORD_W'(cursor_col));
					check_field("cursor_row", WORD_W'(want.cursor_row), WORD_W'(cursor_row));
					check_field("stored", WORD_W'(want.stored), WORD_W'(stored));
					check_field("out_of_grid", WORD_W'(want.out_of_grid),
						WORD_W'(out_of_grid));
				end
			end
			if (in_valid && in_ready)
				expected_cells.push_back(console_update(command, char_code, pos_col,
					pos_row, fg_word, bg_word));
		end
		outstanding    <= expected_cells.size();
		mismatch_count <= fail_total;
	end

endmodule

// ===== bench/text_console_cell_writer_core_tb.sv =====
// Testbench top for text_console_cell_writer_core: clock, reset, stimulus and verdict.
// Depends on tcw_pkg, the core and text_console_cell_writer_checker.
`timescale 1ns / 1ps

module text_console_cell_writer_core_tb;
	import tcw_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;
	localparam int POOL_SIZE   = 40;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index = REG_START_COLUMN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [CMD_W-1:0]      command = CMD_WRITE;
	logic [CHAR_W-1:0]     char_code = '0;
	logic [COL_W-1:0]      pos_col = '0;
	logic [ROW_W-1:0]      pos_row = '0;
	logic [WORD_W-1:0]     fg_word = '0;
	logic [WORD_W-1:0]     bg_word = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [CHAR_W-1:0]     cell_char;
	logic [IDX_W-1:0]      cell_palette_index;
	logic [WORD_W-1:0]     entry_fg;
	logic [WORD_W-1:0]     entry_bg;
	logic [COL_W-1:0]      cursor_col;
	logic [ROW_W-1:0]      cursor_row;
	logic                  stored;
	logic                  out_of_grid;
	int                    mismatch_count;
	int                    outstanding;

	// Stimulus control
	logic                  idle_enable = 1'b1;
	logic                  hold_request = 1'b0;
	int                    quiet_cycles;
	int                    cur_sc, cur_sr, cur_lw, cur_lc;
	logic [WORD_W-1:0]     pool_fg [POOL_SIZE];
	logic [WORD_W-1:0]     pool_bg [POOL_SIZE];

	text_console_cell_writer_core dut (.*);

	text_console_cell_writer_checker scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Count cycles with no handshake on any channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
				(out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: random stalls plus one long hold-off on request
	initial begin : receiver
		int  hold_left;
		bit  hold_served;
		hold_left = 0;
		hold_served = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_served) begin
				hold_served = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(idle_enable && $urandom_range(0, 99) < 8);
			end
		end
	end

	// Offer one item; valid stays high afterwards for the caller to drop or reuse
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
			input logic [WORD_W-1:0] fg, input logic [WORD_W-1:0] bg);
		if (idle_enable && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		char_code <= ch;
		pos_col   <= col;
		pos_row   <= row;
		fg_word   <= fg;
		bg_word   <= bg;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Random command biased toward the active window and a small colour pool
	task automatic send_random_command();
		int                pick;
		int                col_hi;
		int                row_hi;
		logic [CHAR_W-1:0] ch;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [WORD_W-1:0] fg;
		logic [WORD_W-1:0] bg;
		col_hi = (cur_lw - 1 > cur_sc) ? cur_lw - 1 : cur_sc;
		row_hi = (cur_lc - 1 > cur_sr) ? cur_lc - 1 : cur_sr;
		pick = $urandom_range(0, 9);
		ch = CHAR_W'($urandom_range(32, 126));
		if (pick == 0)
			ch = CHAR_NUL;
		else if (pick == 1)
			ch = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
		else if (pick == 2)
			ch = CHAR_W'($urandom_range(0, 255));
		pick = $urandom_range(0, POOL_SIZE - 1);
		fg = pool_fg[pick];
		bg = pool_bg[pick];
		if ($urandom_range(0, 99) < 15) begin
			fg = $urandom;
			bg = $urandom;
		end
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			col = COL_W'($urandom_range(cur_sc, col_hi));
			row = ROW_W'($urandom_range(cur_sr, row_hi));
		end else if (pick < 9) begin
			col = COL_W'($urandom_range(0, 79));
			row = ROW_W'($urandom_range(0, 34));
		end else begin
			col = COL_W'($urandom_range(0, 127));
			row = ROW_W'($urandom_range(0, 63));
		end
		pick = $urandom_range(0, 99);
		if (pick < 58) begin
			send_item(CMD_WRITE, ch, col, row, fg, bg);
		end else if (pick < 73) begin
			// offsets relative to the start position stay inside the window most times
			if (col >= cur_sc && col <= col_hi)
				col = col - COL_W'(cur_sc);
			if (row >= cur_sr && row <= row_hi)
				row = row - ROW_W'(cur_sr);
			send_item(CMD_SET_POS, ch, col, row, fg, bg);
		end else if (pick < 95) begin
			send_item(CMD_READ, ch, col, row, fg, bg);
		end else begin
			send_item(CMD_UNUSED, ch, col, row, fg, bg);
		end
	endtask

	// Reconfigure while idle, then run a batch of random commands
	task automatic run_phase(input int sc, input int sr, input int lw, input int lc,
			input int count, input bit idles, input bit squeeze);
		wait_drained();
		cur_sc = sc;
		cur_sr = sr;
		cur_lw = lw;
		cur_lc = lc;
		write_reg(REG_START_COLUMN, CFG_DATA_W'(sc));
		write_reg(REG_START_ROW, CFG_DATA_W'(sr));
		write_reg(REG_LINE_WIDTH, CFG_DATA_W'(lw));
		write_reg(REG_LINE_COUNT, CFG_DATA_W'(lc));
		cfg_valid <= 1'b0;
		idle_enable <= idles;
		if (squeeze)
			hold_request <= 1'b1;
		repeat (count) send_random_command();
		in_valid <= 1'b0;
	endtask

	initial begin : stimulus
		cur_sc = int'(START_COLUMN_RST);
		cur_sr = int'(START_ROW_RST);
		cur_lw = int'(LINE_WIDTH_RST);
		cur_lc = int'(LINE_COUNT_RST);
		pool_fg[0] = '0;
		pool_bg[0] = '0;
		for (int i = 1; i < POOL_SIZE; i++) begin
			pool_fg[i] = $urandom;
			pool_bg[i] = $urandom;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset contents, corners, palette reuse and replacement
		send_item(CMD_READ, 8'h00, 7'd0, 6'd0, '0, '0);
		send_item(CMD_READ, 8'h00, 7'd79, 6'd34, '0, '0);
		send_item(CMD_READ, 8'h00, 7'd80, 6'd0, '0, '0);
		send_item(CMD_READ, 8'hFF, 7'd127, 6'd63, '1, '1);
		send_item(CMD_WRITE, 8'h41, 7'd0, 6'd0, '0, '0);
		send_item(CMD_WRITE, CHAR_TILDE, 7'd0, 6'd0, '1, '1);
		send_item(CMD_WRITE, CHAR_SPACE, 7'd0, 6'd0, '0, '0);
		send_item(CMD_WRITE, CHAR_NUL, 7'd0, 6'd0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		// non-printable bytes touch neither cell nor palette
		send_item(CMD_WRITE, 8'h7F, 7'd0, 6'd0, 32'h1234_5678, 32'h9ABC_DEF0);
		send_item(CMD_WRITE, 8'h1F, 7'd0, 6'd0, 32'h1234_5678, 32'h9ABC_DEF0);
		send_item(CMD_WRITE, 8'hFF, 7'd0, 6'd0, '1, '0);
		send_item(CMD_WRITE, 8'h80, 7'd0, 6'd0, '0, '1);
		send_item(CMD_WRITE, CHAR_CR, 7'd0, 6'd0, '0, '0);
		send_item(CMD_WRITE, CHAR_LF, 7'd0, 6'd0, '0, '0);
		send_item(CMD_READ, 8'h00, 7'd24, 6'd16, '0, '0);
		send_item(CMD_READ, 8'h00, 7'd25, 6'd16, '0, '0);
		send_item(CMD_READ, 8'h00, 7'd26, 6'd16, '0, '0);
		send_item(CMD_UNUSED, 8'h55, 7'd33, 6'd21, '1, '1);
		send_item(CMD_SET_POS, 8'h00, 7'd0, 6'd0, '0, '0);
		send_item(CMD_WRITE, 8'h78, 7'd0, 6'd0, 32'hFF00_FF00, 32'h00FF_00FF);
		// cursor placed past the grid: write is dropped, cursor still moves
		send_item(CMD_SET_POS, 8'h00, 7'd79, 6'd34, '0, '0);
		send_item(CMD_WRITE, 8'h79, 7'd0, 6'd0, '0, '0);
		// last column and last row wrap to the start row
		send_item(CMD_SET_POS, 8'h00, 7'd70, 6'd30, '0, '0);
		send_item(CMD_WRITE, 8'h7A, 7'd0, 6'd0, '0, '0);
		send_item(CMD_SET_POS, 8'h00, 7'd127, 6'd63, '0, '0);
		in_valid <= 1'b0;

		// Random phases over several settings, extremes included
		run_phase(0, 0, 80, 35, 300, 1'b1, 1'b0);
		run_phase(79, 34, 1, 1, 150, 1'b1, 1'b0);
		run_phase(2, 3, 12, 8, 350, 1'b0, 1'b0);
		run_phase(40, 20, 80, 35, 300, 1'b1, 1'b1);
		repeat (3)
			run_phase($urandom_range(0, 79), $urandom_range(0, 34), $urandom_range(1, 80),
				$urandom_range(1, 35), 180, 1'b1, 1'b0);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
